FILE: rtl/kstn_pkg.sv
// shared types, constants and widths for the key scan to note event block
`default_nettype none
package kstn_pkg;

  // keyboard geometry
  localparam int NUM_KEYS   = 24;
  localparam int KEY_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int LEVELS_W   = 24;
  localparam int MAX_EVENTS = 24;

  // field widths
  localparam int NOTE_W  = 7;
  localparam int SLOTS_W = 5;
  localparam int KIDX_W  = 5;
  localparam int SHIFT_W = 4;
  localparam int LIM_W   = 3;
  localparam int OFF_W   = 9;
  localparam int SUM_W   = 11;
  localparam int CNT_W   = 5;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_NOTE     = 2'd0,
    CFG_SHIFT_FLOOR   = 2'd1,
    CFG_SHIFT_CEILING = 2'd2
  } cfg_idx_t;

  localparam logic [NOTE_W-1:0] BASE_NOTE_RST     = 7'd48;
  localparam logic [LIM_W-1:0]  SHIFT_FLOOR_RST   = 3'b110;
  localparam logic [LIM_W-1:0]  SHIFT_CEILING_RST = 3'd2;
  localparam logic [NOTE_W-1:0] NOTE_MAX          = 7'd127;

  // one scan snapshot
  typedef struct packed {
    logic [LEVELS_W-1:0] key_levels;
    logic                down_button;
    logic                up_button;
    logic [SLOTS_W-1:0]  free_slots;
  } in_item_t;

  // one note event
  typedef struct packed {
    logic              note_on;
    logic [NOTE_W-1:0] note_number;
    logic [KIDX_W-1:0] key_index;
    logic              last;
  } out_item_t;

  // work handed to the key walker for one scan
  typedef struct packed {
    logic                    start;
    logic [LEVELS_W-1:0]     levels;
    logic [SLOTS_W-1:0]      room;
    logic signed [OFF_W-1:0] offset;
  } scan_cmd_t;

  // walker status
  typedef struct packed {
    logic idle;
  } scan_stat_t;

  // walker sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } scan_state_t;

endpackage
`default_nettype wire

FILE: rtl/key_scan_to_note_events.sv
// top level: configuration, octave shift tracking and the key walker
// Each accepted scan snapshot is walked in index order by a sequencer around a
// single note adder and one read port of the latched note ram, one key per cycle
// while no event has to wait for the consumer to take the full output register.
// After the last key any final event is released with its last flag, and the
// walker returns to idle; that release also waits while the output is full.
// in_ready is high only while idle. Events leave through a registered output,
// one transaction per event; a scan that changes nothing gives no transaction.
// Octave button edges are applied as the snapshot is taken. Configuration
// writes are always accepted (cfg_ready tied high), indexes beyond the
// register list are ignored.
`default_nettype none
module key_scan_to_note_events (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  kstn_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output kstn_pkg::out_item_t                 out_item,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [kstn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [kstn_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [kstn_pkg::NOTE_W-1:0]         base_r;
  logic [kstn_pkg::LIM_W-1:0]          floor_r;
  logic [kstn_pkg::LIM_W-1:0]          ceil_r;
  logic signed [kstn_pkg::SHIFT_W-1:0] shift_r, shift_nxt;
  logic                                down_r, up_r;

  logic                                accept;
  logic signed [4:0]                   sh5, sh_dn, floor5, ceil5;
  logic signed [kstn_pkg::OFF_W-1:0]   sh9, offset;
  kstn_pkg::scan_cmd_t                 cmd;
  kstn_pkg::scan_stat_t                stat;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid & in_ready;
  assign in_ready  = stat.idle;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= kstn_pkg::BASE_NOTE_RST;
      floor_r <= kstn_pkg::SHIFT_FLOOR_RST;
      ceil_r  <= kstn_pkg::SHIFT_CEILING_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        kstn_pkg::CFG_BASE_NOTE:     base_r  <= cfg_data;
        kstn_pkg::CFG_SHIFT_FLOOR:   floor_r <= cfg_data[kstn_pkg::LIM_W-1:0];
        kstn_pkg::CFG_SHIFT_CEILING: ceil_r  <= cfg_data[kstn_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // octave shift: down edge first, then up edge, each within its limit
  assign floor5 = $signed({{2{floor_r[kstn_pkg::LIM_W-1]}}, floor_r});
  assign ceil5  = $signed({2'b00, ceil_r});
  assign sh5    = $signed({shift_r[kstn_pkg::SHIFT_W-1], shift_r});

  always_comb begin
    sh_dn = sh5;
    if (in_item.down_button && !down_r && (sh5 > floor5)) begin
      sh_dn = sh5 - 5'sd1;
    end
    if (in_item.up_button && !up_r && (sh_dn < ceil5)) begin
      sh_dn = sh_dn + 5'sd1;
    end
    shift_nxt = sh_dn[kstn_pkg::SHIFT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      down_r  <= 1'b0;
      up_r    <= 1'b0;
    end else if (accept) begin
      shift_r <= shift_nxt;
      down_r  <= in_item.down_button;
      up_r    <= in_item.up_button;
    end
  end

  // scan offset: base note plus twelve times the new shift
  assign sh9    = $signed({{(kstn_pkg::OFF_W - kstn_pkg::SHIFT_W){shift_nxt[kstn_pkg::SHIFT_W-1]}},
                           shift_nxt});
  assign offset = $signed({{(kstn_pkg::OFF_W - kstn_pkg::NOTE_W){1'b0}}, base_r})
                + (sh9 <<< 3) + (sh9 <<< 2);

  always_comb begin
    cmd.start  = accept;
    cmd.levels = in_item.key_levels;
    cmd.room   = in_item.free_slots;
    cmd.offset = offset;
  end

  // key walker
  kstn_scan_ctrl u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

FILE: rtl/kstn_ram.sv
// generic single write port ram with registered read
`default_nettype none
module kstn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                                          clk,
  input  wire                                          we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                             wdata,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/kstn_note_alu.sv
// note adder: scan offset plus key index, clamped to the midi note range
`default_nettype none
module kstn_note_alu (
  input  wire  signed [kstn_pkg::OFF_W-1:0] offset,
  input  wire         [kstn_pkg::KEY_W-1:0] key,
  output logic        [kstn_pkg::NOTE_W-1:0] note
);

  logic signed [kstn_pkg::SUM_W-1:0] sum;

  // extend both operands and add
  assign sum = $signed({{(kstn_pkg::SUM_W - kstn_pkg::OFF_W){offset[kstn_pkg::OFF_W-1]}},
                        offset})
             + $signed({{(kstn_pkg::SUM_W - kstn_pkg::KEY_W){1'b0}}, key});

  // clamp to 0..127
  always_comb begin
    if (sum < 0) begin
      note = '0;
    end else if (sum > $signed(kstn_pkg::SUM_W'(kstn_pkg::NOTE_MAX))) begin
      note = kstn_pkg::NOTE_MAX;
    end else begin
      note = sum[kstn_pkg::NOTE_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/kstn_scan_ctrl.sv
// key walker: visits one key per cycle unless an event waits on the full output, holds one event back for the last flag
`default_nettype none
module kstn_scan_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  kstn_pkg::scan_cmd_t    cmd,
  output kstn_pkg::scan_stat_t   stat,
  output logic                   out_valid,
  input  wire                    out_ready,
  output kstn_pkg::out_item_t    out_item
);

  kstn_pkg::scan_state_t st_r, st_nxt;

  logic [kstn_pkg::KEY_W-1:0]        key_r, key_nxt;
  logic [kstn_pkg::LEVELS_W-1:0]     lv_r, lv_nxt;
  logic [kstn_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [kstn_pkg::SLOTS_W-1:0]      room_r, room_nxt;
  logic signed [kstn_pkg::OFF_W-1:0] off_r, off_nxt;
  logic [kstn_pkg::NUM_KEYS-1:0]     was_r, was_nxt;
  kstn_pkg::out_item_t               pend_r, pend_nxt;
  logic                              pend_v_r, pend_v_nxt;
  kstn_pkg::out_item_t               out_r, out_nxt;
  logic                              out_v_r, out_v_nxt;

  logic                         held, was, press, rel, ev, advance, slot_free, key_last;
  logic [kstn_pkg::NOTE_W-1:0]  new_note, latched_note;
  logic                         ram_we;
  logic [31:0]                  key_wide;
  kstn_pkg::out_item_t          new_ev;

  // shared note adder
  kstn_note_alu u_alu (
    .offset (off_r),
    .key    (key_r),
    .note   (new_note)
  );

  // latched note per key, addressed with the next key so the registered read matches the current key
  kstn_ram #(
    .WIDTH (kstn_pkg::NOTE_W),
    .DEPTH (kstn_pkg::NUM_KEYS)
  ) u_note_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (key_r),
    .wdata (new_note),
    .raddr (key_nxt),
    .rdata (latched_note)
  );

  // current key decode
  assign held      = lv_r[0];
  assign was       = was_r[key_r];
  assign press     = held & ~was;
  assign rel       = ~held & was;
  assign ev        = (press | rel) & (cnt_r < room_r);
  assign slot_free = ~out_v_r | out_ready;
  assign key_last  = (key_r == kstn_pkg::KEY_W'(kstn_pkg::NUM_KEYS - 1));
  assign key_wide  = 32'(key_r);

  always_comb begin
    new_ev.note_on     = press;
    new_ev.note_number = press ? new_note : latched_note;
    new_ev.key_index   = key_wide[kstn_pkg::KIDX_W-1:0];
    new_ev.last        = 1'b0;
  end

  // sequencer
  always_comb begin
    st_nxt     = st_r;
    key_nxt    = key_r;
    lv_nxt     = lv_r;
    cnt_nxt    = cnt_r;
    room_nxt   = room_r;
    off_nxt    = off_r;
    was_nxt    = was_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r & ~out_ready;
    ram_we     = 1'b0;
    advance    = 1'b0;
    case (st_r)
      kstn_pkg::ST_IDLE: begin
        if (cmd.start) begin
          lv_nxt   = cmd.levels;
          off_nxt  = cmd.offset;
          room_nxt = (cmd.room > kstn_pkg::SLOTS_W'(kstn_pkg::MAX_EVENTS))
                     ? kstn_pkg::SLOTS_W'(kstn_pkg::MAX_EVENTS) : cmd.room;
          cnt_nxt  = '0;
          key_nxt  = '0;
          st_nxt   = kstn_pkg::ST_SCAN;
        end
      end
      kstn_pkg::ST_SCAN: begin
        advance = 1'b1;
        if (ev) begin
          if (pend_v_r && !slot_free) begin
            advance = 1'b0;
          end else begin
            if (pend_v_r) begin
              out_nxt      = pend_r;
              out_nxt.last = 1'b0;
              out_v_nxt    = 1'b1;
            end
            pend_nxt       = new_ev;
            pend_v_nxt     = 1'b1;
            cnt_nxt        = cnt_r + 1'b1;
            was_nxt[key_r] = press;
            ram_we         = press;
          end
        end
        if (advance) begin
          lv_nxt = {1'b0, lv_r[kstn_pkg::LEVELS_W-1:1]};
          if (key_last) begin
            key_nxt = '0;
            st_nxt  = kstn_pkg::ST_FLUSH;
          end else begin
            key_nxt = key_r + 1'b1;
          end
        end
      end
      kstn_pkg::ST_FLUSH: begin
        if (!pend_v_r) begin
          st_nxt = kstn_pkg::ST_IDLE;
        end else if (slot_free) begin
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
          out_v_nxt    = 1'b1;
          pend_v_nxt   = 1'b0;
          st_nxt       = kstn_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = kstn_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= kstn_pkg::ST_IDLE;
      key_r    <= '0;
      was_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      key_r    <= key_nxt;
      was_r    <= was_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // payload and scan working registers
  always_ff @(posedge clk) begin
    lv_r   <= lv_nxt;
    cnt_r  <= cnt_nxt;
    room_r <= room_nxt;
    off_r  <= off_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign stat.idle = (st_r == kstn_pkg::ST_IDLE);
  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

FILE: test/kstn_event_checker.sv
// checker for the key scan block: predicts the note events of each scan and compares them
`timescale 1ns / 1ps
module kstn_event_checker (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  input  wire                             in_ready,
  input  kstn_pkg::in_item_t              in_item,
  input  wire                             out_valid,
  input  wire                             out_ready,
  input  kstn_pkg::out_item_t             out_item,
  input  wire                             cfg_valid,
  input  wire                             cfg_ready,
  input  wire  [kstn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [kstn_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              events_pending
);
  import kstn_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // configuration as last written
  logic [NOTE_W-1:0]         base_note_q;
  logic signed [LIM_W-1:0]   floor_q;
  logic [LIM_W-1:0]          ceiling_q;

  // keyboard state as the block should hold it
  logic signed [SHIFT_W-1:0] shift_q;
  logic                      down_held_q;
  logic                      up_held_q;
  logic [NUM_KEYS-1:0]       key_held_q;
  logic [NOTE_W-1:0]         latched_note_q [NUM_KEYS];

  out_item_t expected_events [$];

  // counts a failure and says whether it is still worth printing
  function automatic bit may_report();
    mismatch_count++;
    return mismatch_count <= REPORT_LIMIT;
  endfunction

  // works out the events of one scan and queues them in order
  function automatic void predict_note_events(in_item_t scan);
    out_item_t held_ev;
    bit        have_ev;
    int        room;
    int        made;
    int        note;
    int        k;
    logic      held;
    room    = (scan.free_slots > MAX_EVENTS) ? MAX_EVENTS : int'(scan.free_slots);
    made    = 0;
    have_ev = 1'b0;
    held_ev = '0;
    // octave buttons act on their rising edge, down before up
    if (scan.down_button && !down_held_q && int'(shift_q) > int'(floor_q))
      shift_q = shift_q - 1;
    if (scan.up_button && !up_held_q && int'(shift_q) < int'(ceiling_q))
      shift_q = shift_q + 1;
    down_held_q = scan.down_button;
    up_held_q   = scan.up_button;
    // visit keys in order; a key left alone for lack of room retries next scan
    for (k = 0; k < NUM_KEYS; k++) begin
      held = scan.key_levels[k];
      if (made < room && held != key_held_q[k]) begin
        if (held) begin
          note = int'(base_note_q) + k + 12 * int'(shift_q);
          if (note < 0)
            note = 0;
          if (note > int'(NOTE_MAX))
            note = int'(NOTE_MAX);
          latched_note_q[k] = note[NOTE_W-1:0];
        end
        key_held_q[k] = held;
        if (have_ev)
          expected_events.push_back(held_ev);
        held_ev.note_on     = held;
        held_ev.note_number = latched_note_q[k];
        held_ev.key_index   = k[KIDX_W-1:0];
        held_ev.last        = 1'b0;
        have_ev = 1'b1;
        made++;
      end
    end
    // the final event of the scan carries the last flag
    if (have_ev) begin
      held_ev.last = 1'b1;
      expected_events.push_back(held_ev);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      base_note_q = BASE_NOTE_RST;
      floor_q     = SHIFT_FLOOR_RST;
      ceiling_q   = SHIFT_CEILING_RST;
      shift_q     = '0;
      down_held_q = 1'b0;
      up_held_q   = 1'b0;
      key_held_q  = '0;
      expected_events.delete();
    end else begin
      // event leaving the block against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          if (may_report())
            $display("unexpected event: on=%0d note=%0d key=%0d last=%0d",
                     out_item.note_on, out_item.note_number, out_item.key_index,
                     out_item.last);
        end else begin
          if (out_item.note_on !== expected_events[0].note_on ||
              out_item.note_number !== expected_events[0].note_number ||
              out_item.key_index !== expected_events[0].key_index ||
              out_item.last !== expected_events[0].last) begin
            if (may_report())
              $display("event mismatch: expected on=%0d note=%0d key=%0d last=%0d, got on=%0d note=%0d key=%0d last=%0d",
                       expected_events[0].note_on, expected_events[0].note_number,
                       expected_events[0].key_index, expected_events[0].last,
                       out_item.note_on, out_item.note_number, out_item.key_index,
                       out_item.last);
          end
          void'(expected_events.pop_front());
        end
      end
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE_NOTE:     base_note_q = cfg_data[NOTE_W-1:0];
          CFG_SHIFT_FLOOR:   floor_q     = cfg_data[LIM_W-1:0];
          CFG_SHIFT_CEILING: ceiling_q   = cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
      // scan transaction
      if (in_valid && in_ready)
        predict_note_events(in_item);
    end
    events_pending = expected_events.size();
  end

endmodule

FILE: test/tb_key_scan_to_note_events.sv
// testbench top for the key scan block: clock, reset, scan and register stimulus, verdict
`timescale 1ns / 1ps
module tb_key_scan_to_note_events;
  import kstn_pkg::*;

  localparam int RESET_CYCLES  = 7;
  localparam int SCAN_CYCLES   = NUM_KEYS + 2;
  localparam int SETTLE_CYCLES = 2 * SCAN_CYCLES + 8;
  localparam int PHASE_ITEMS   = 50;
  localparam int LEAN_SPAN     = 25;
  localparam int GAP_MAX       = 8;
  localparam int BURST_MAX     = 16;
  localparam int STALL_MAX     = 20;
  localparam int QUIET_LIMIT   = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {RX_OPEN, RX_COIN, RX_STALLS} rx_mode_t;
  typedef enum int {LEAN_BOTH, LEAN_UP, LEAN_DOWN} lean_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int       mismatch_count;
  int       events_pending;
  int       burst_left;
  int       quiet_cycles;
  int       rx_tick;
  int       stall_left;
  rx_mode_t rx_mode;
  lean_t    octave_lean;
  in_item_t last_scan;

  key_scan_to_note_events u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kstn_event_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .events_pending (events_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // event receiver: always open, coin toss, or long stalls, in a randomly drawn mode
  initial begin
    rx_tick    = 0;
    stall_left = 0;
    rx_mode    = RX_OPEN;
  end

  always @(negedge clk) begin
    if (rx_tick == 0)
      rx_mode = rx_mode_t'($urandom_range(0, 2));
    rx_tick = (rx_tick + 1) % 200;
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, STALL_MAX - 1);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_scan(logic [LEVELS_W-1:0] levels, logic down, logic up,
                                         logic [SLOTS_W-1:0] slots);
    in_item_t s;
    s.key_levels  = levels;
    s.down_button = down;
    s.up_button   = up;
    s.free_slots  = slots;
    return s;
  endfunction

  // next scan: mostly a few keys changing, sometimes chords, noise or no room
  function automatic in_item_t next_scan(in_item_t prev);
    in_item_t s;
    int       kind;
    s    = prev;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      repeat ($urandom_range(1, 4))
        s.key_levels = s.key_levels ^ (24'd1 << $urandom_range(0, NUM_KEYS - 1));
    end else if (kind == 6) begin
      s.key_levels = LEVELS_W'($urandom);
    end else if (kind == 7) begin
      s.key_levels = (prev.key_levels == '0) ? '1 : '0;
    end
    // octave buttons, leaning one way for a while so the limits get reached
    case (octave_lean)
      LEAN_UP: begin
        s.down_button = 1'b0;
        if ($urandom_range(0, 1) == 0)
          s.up_button = ~s.up_button;
      end
      LEAN_DOWN: begin
        s.up_button = 1'b0;
        if ($urandom_range(0, 1) == 0)
          s.down_button = ~s.down_button;
      end
      default: begin
        if ($urandom_range(0, 3) == 0)
          s.down_button = ~s.down_button;
        if ($urandom_range(0, 3) == 0)
          s.up_button = ~s.up_button;
      end
    endcase
    s.free_slots = ($urandom_range(0, 3) == 0) ? SLOTS_W'($urandom_range(0, 31))
                                               : SLOTS_W'($urandom_range(NUM_KEYS, 31));
    return s;
  endfunction

  // one scan transaction, sent in bursts with random gaps between them
  task automatic send_scan(in_item_t scan);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, GAP_MAX);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? BURST_MAX * 4 : $urandom_range(1, BURST_MAX);
    end
    in_valid <= 1'b1;
    in_item  <= scan;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    burst_left--;
  endtask

  // hold the sender until every predicted event has come out
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (events_pending != 0)
      @(negedge clk);
  endtask

  // drained, and the walker given time to finish a scan with no events
  task automatic settle();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] floor_val,
                           logic [CFG_DATA_W-1:0] ceil_val);
    settle();
    write_reg(CFG_BASE_NOTE, base);
    write_reg(CFG_SHIFT_FLOOR, floor_val);
    write_reg(CFG_SHIFT_CEILING, ceil_val);
  endtask

  task automatic run_random(int count);
    int j;
    for (j = 0; j < count; j++) begin
      if (j % LEAN_SPAN == 0)
        octave_lean = lean_t'($urandom_range(0, 2));
      if (j == count / 2)
        wait_for_drain();
      last_scan = next_scan(last_scan);
      send_scan(last_scan);
    end
  endtask

  initial begin
    burst_left   = 0;
    octave_lean  = LEAN_BOTH;
    last_scan    = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed scans at the reset settings: base 48, shift limits -2 and +2
    send_scan(make_scan(24'hFFFFFF, 1'b0, 1'b0, 5'd24)); // every key pressed
    send_scan(make_scan(24'h000000, 1'b0, 1'b0, 5'd31)); // room above the key count
    send_scan(make_scan(24'h000000, 1'b0, 1'b0, 5'd0));  // nothing changes
    send_scan(make_scan(24'hFFFFFF, 1'b0, 1'b0, 5'd5));  // room runs out
    send_scan(make_scan(24'hFFFFFF, 1'b0, 1'b0, 5'd0));  // no room at all
    send_scan(make_scan(24'hFFFFFF, 1'b0, 1'b0, 5'd24)); // retried keys
    send_scan(make_scan(24'h000000, 1'b0, 1'b0, 5'd3));
    send_scan(make_scan(24'h000000, 1'b0, 1'b0, 5'd25));
    send_scan(make_scan(24'h000001, 1'b0, 1'b1, 5'd24)); // octave up edge
    send_scan(make_scan(24'h000001, 1'b0, 1'b1, 5'd24)); // button held, no edge
    send_scan(make_scan(24'h000000, 1'b0, 1'b0, 5'd24));
    send_scan(make_scan(24'h000020, 1'b0, 1'b1, 5'd1));
    send_scan(make_scan(24'h000020, 1'b0, 1'b0, 5'd24));
    send_scan(make_scan(24'h000040, 1'b0, 1'b1, 5'd24)); // at the ceiling, latched note off
    send_scan(make_scan(24'h000040, 1'b1, 1'b0, 5'd24));
    send_scan(make_scan(24'h000000, 1'b1, 1'b0, 5'd24));
    send_scan(make_scan(24'h000000, 1'b0, 1'b0, 5'd24));
    send_scan(make_scan(24'h000000, 1'b1, 1'b0, 5'd0));
    send_scan(make_scan(24'h000000, 1'b0, 1'b0, 5'd0));
    send_scan(make_scan(24'h000000, 1'b1, 1'b0, 5'd0));
    send_scan(make_scan(24'h000000, 1'b0, 1'b0, 5'd0));
    send_scan(make_scan(24'h000000, 1'b1, 1'b0, 5'd0));
    send_scan(make_scan(24'h000000, 1'b0, 1'b0, 5'd0));
    send_scan(make_scan(24'h800001, 1'b1, 1'b0, 5'd24)); // at the floor
    send_scan(make_scan(24'h000000, 1'b1, 1'b1, 5'd24)); // both buttons together
    last_scan = make_scan(24'h000000, 1'b1, 1'b1, 5'd24);
    run_random(PHASE_ITEMS);

    // top of the note range, shift limits -4 and +4
    configure(7'd127, 7'h04, 7'd4);
    run_random(PHASE_ITEMS);
    // bottom of the note range
    configure(7'd0, 7'h04, 7'd4);
    run_random(PHASE_ITEMS);
    // floor above zero and above the ceiling
    configure(7'd0, 7'h03, 7'd1);
    run_random(PHASE_ITEMS);
    // ceiling beyond the usual range
    configure(7'd64, 7'h00, 7'd7);
    run_random(PHASE_ITEMS);
    configure(7'd100, 7'h07, 7'd0);
    run_random(PHASE_ITEMS);

    // random settings, upper data bits included, plus a write to an unused index
    settle();
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 127)));
    write_reg(CFG_BASE_NOTE, CFG_DATA_W'($urandom_range(0, 127)));
    write_reg(CFG_SHIFT_FLOOR, CFG_DATA_W'($urandom_range(0, 127)));
    write_reg(CFG_SHIFT_CEILING, CFG_DATA_W'($urandom_range(0, 127)));
    run_random(PHASE_ITEMS);

    settle();
    if (mismatch_count == 0 && events_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: key_scan_to_note_events.f
rtl/kstn_pkg.sv
rtl/kstn_ram.sv
rtl/kstn_note_alu.sv
rtl/kstn_scan_ctrl.sv
rtl/key_scan_to_note_events.sv
test/kstn_event_checker.sv
test/tb_key_scan_to_note_events.sv
